[hdl/ihb_pkg.sv]
// Shared types and header constants for the IPv4 header builder.
package ihb_pkg;

	localparam int unsigned HdrWords   = 5;
	localparam int unsigned WordIdxW   = 3;
	localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(HdrWords - 1);

	// Fixed header fields.
	localparam logic [15:0] VerIhlTos = 16'h4500;
	localparam logic [15:0] IdentVal  = 16'h0001;
	localparam logic [15:0] FlagsFrag = 16'h4000;
	localparam logic [7:0]  TtlVal    = 8'h40;
	localparam logic [15:0] HdrBytes  = 16'd20;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_OWN_ADDRESS    = 2'd0,
		CFG_NET_MASK       = 2'd1,
		CFG_ROUTER_ADDRESS = 2'd2
	} cfg_reg_t;

	// One fully computed header plus its routing decision.
	typedef struct packed {
		logic [15:0] total_len;
		logic [7:0]  proto;
		logic [15:0] csum;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] hop;
		logic        via;
	} hdr_rec_t;

endpackage

[hdl/ihb_calc.sv]
// Header field, checksum and next-hop computation for one registered request.
module ihb_calc (
	input  logic [31:0]        dst_addr,
	input  logic [7:0]         proto,
	input  logic [15:0]        payload_len,
	input  logic [31:0]        own_addr,
	input  logic [31:0]        mask,
	input  logic [31:0]        router_addr,
	output ihb_pkg::hdr_rec_t  rec
);

	localparam logic [19:0] ConstSum = 20'(ihb_pkg::VerIhlTos) + 20'(ihb_pkg::IdentVal)
		+ 20'(ihb_pkg::FlagsFrag);

	logic [15:0] total_len;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic        off_net;

	assign total_len = payload_len + ihb_pkg::HdrBytes;

	// Ones' complement sum of the ten 16-bit header halves, checksum field as zero.
	assign sum = ConstSum + 20'({ihb_pkg::TtlVal, proto}) + 20'(total_len)
		+ 20'(own_addr[31:16]) + 20'(own_addr[15:0])
		+ 20'(dst_addr[31:16]) + 20'(dst_addr[15:0]);

	// Two end-around carry folds always suffice for a 20-bit sum.
	assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	assign off_net = (dst_addr & mask) != (own_addr & mask);

	always_comb begin
		rec.total_len = total_len;
		rec.proto     = proto;
		rec.csum      = ~fold2;
		rec.src_addr  = own_addr;
		rec.dst_addr  = dst_addr;
		rec.hop       = off_net ? router_addr : dst_addr;
		rec.via       = off_net;
	end

endmodule

[hdl/ihb_serializer.sv]
// Result register that holds one header and hands it out one word at a time.
module ihb_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ld_valid,
	output logic                ld_ready,
	input  ihb_pkg::hdr_rec_t   rec,
	output logic                word_valid,
	input  logic                word_ready,
	output logic [31:0]         header_word,
	output logic [2:0]          word_number,
	output logic                last_word,
	output logic [31:0]         next_hop,
	output logic                via_router
);

	ihb_pkg::hdr_rec_t rec_q;
	logic [ihb_pkg::WordIdxW-1:0] cnt_q;
	logic full_q;
	logic is_last;
	logic take;

	assign is_last  = cnt_q == ihb_pkg::LastWordIdx;
	assign take     = full_q && word_ready;
	assign ld_ready = !full_q || (take && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ld_valid && ld_ready) begin
			full_q <= 1'b1;
			cnt_q  <= '0;
		end else if (take) begin
			if (is_last) begin
				full_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid && ld_ready) begin
			rec_q <= rec;
		end
	end

	always_comb begin
		unique case (cnt_q)
			3'd0:    header_word = {ihb_pkg::VerIhlTos, rec_q.total_len};
			3'd1:    header_word = {ihb_pkg::IdentVal, ihb_pkg::FlagsFrag};
			3'd2:    header_word = {ihb_pkg::TtlVal, rec_q.proto, rec_q.csum};
			3'd3:    header_word = rec_q.src_addr;
			3'd4:    header_word = rec_q.dst_addr;
			default: header_word = '0;
		endcase
	end

	assign word_valid  = full_q;
	assign word_number = cnt_q;
	assign last_word   = is_last;
	assign next_hop    = rec_q.hop;
	assign via_router  = rec_q.via;

endmodule

[hdl/ipv4_header_builder_top.sv]
// Top level of the IPv4 header builder: configuration, request register and output stage.
//
// Usage: a request word (dest_address, proto_number, payload_bytes) enters on the
// req_valid/req_ready channel. For each request the block sends five header words on
// the word_valid/word_ready channel, in wire order, numbered 0 to 4 by word_number and
// with last_word set on the fifth. Every word also carries next_hop and via_router:
// the destination when it is on the local subnet, otherwise the gateway.
// Configuration registers are written through cfg_valid/cfg_ready with cfg_index
// (0 own address, 1 net mask, 2 router address; index 3 is ignored) and cfg_data.
// They should only be changed while no request is in flight.
//
// An accepted request sits in the request register and is moved into the output
// stage when that stage is free; word 0 is valid once the output stage holds it.
// The single output port moves one header word per cycle while word_ready is high,
// and the next request waits in the request register while the current header
// drains, so the input is taken early.
// Reset clears all configuration registers to zero and empties both stages.
// When the receiver stalls, the current word holds and the request register fills,
// after which req_ready drops until the output stage frees up.
module ipv4_header_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Request channel.
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [31:0] dest_address,
	input  logic [7:0]  proto_number,
	input  logic [15:0] payload_bytes,
	// Header word channel.
	output logic        word_valid,
	input  logic        word_ready,
	output logic [31:0] header_word,
	output logic [2:0]  word_number,
	output logic        last_word,
	output logic [31:0] next_hop,
	output logic        via_router
);

	logic [31:0] own_addr_q;
	logic [31:0] mask_q;
	logic [31:0] router_q;

	logic        valid_s1;
	logic [31:0] dst_s1;
	logic [7:0]  proto_s1;
	logic [15:0] len_s1;

	ihb_pkg::hdr_rec_t rec;
	logic ld_ready;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			mask_q     <= '0;
			router_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ihb_pkg::CFG_OWN_ADDRESS:    own_addr_q <= cfg_data;
				ihb_pkg::CFG_NET_MASK:       mask_q     <= cfg_data;
				ihb_pkg::CFG_ROUTER_ADDRESS: router_q   <= cfg_data;
				default:                     ;
			endcase
		end
	end

	// The request register accepts a new word whenever it is empty or being
	// handed to the output stage in this cycle.
	assign req_ready = !valid_s1 || ld_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			dst_s1   <= dest_address;
			proto_s1 <= proto_number;
			len_s1   <= payload_bytes;
		end
	end

	ihb_calc u_calc (
		.dst_addr    (dst_s1),
		.proto       (proto_s1),
		.payload_len (len_s1),
		.own_addr    (own_addr_q),
		.mask        (mask_q),
		.router_addr (router_q),
		.rec         (rec)
	);

	ihb_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld_valid    (valid_s1),
		.ld_ready    (ld_ready),
		.rec         (rec),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.header_word (header_word),
		.word_number (word_number),
		.last_word   (last_word),
		.next_hop    (next_hop),
		.via_router  (via_router)
	);

endmodule

[hdl/ihb_checker.sv]
// Port-level checks for the IPv4 header builder and their bind to the top level.
module ihb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        word_valid,
	input logic        word_ready,
	input logic [31:0] header_word,
	input logic [2:0]  word_number,
	input logic        last_word,
	input logic [31:0] next_hop,
	input logic        via_router
);

	// A stalled word keeps its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(header_word)
			&& $stable(word_number))
		else $error("header word changed while stalled");

	// Words of one header follow without a gap in numbering.
	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready && !last_word |=> word_valid
			&& word_number == $past(word_number) + 3'd1)
		else $error("header word sequence broken");

	// The last flag marks word four and only word four.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> last_word == (word_number == ihb_pkg::LastWordIdx))
		else $error("last flag does not match word number");

	// The routing decision is the same for all words of one header.
	a_hop_const: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready && !last_word |=> $stable(next_hop)
			&& $stable(via_router))
		else $error("next hop changed within a header");

endmodule

bind ipv4_header_builder_top ihb_checker u_ihb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.word_valid  (word_valid),
	.word_ready  (word_ready),
	.header_word (header_word),
	.word_number (word_number),
	.last_word   (last_word),
	.next_hop    (next_hop),
	.via_router  (via_router)
);

[tb/sv/ipv4_header_builder_top_tb.sv]
// Self-checking testbench for the IPv4 header builder, with an own header predictor.
`timescale 1ns / 100ps

module ipv4_header_builder_top_tb;
	import ihb_pkg::*;

	// Index 3 has no register behind it; writes to it must leave the configuration alone.
	localparam logic [1:0] CfgIdxUnused = 2'd3;

	// One expected header word with the routing fields that travel with it.
	typedef struct {
		logic [31:0] header;
		logic [2:0]  number;
		logic        last;
		logic [31:0] hop;
		logic        via;
	} hdr_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        req_valid;
	logic        req_ready;
	logic [31:0] dest_address;
	logic [7:0]  proto_number;
	logic [15:0] payload_bytes;
	logic        word_valid;
	logic        word_ready;
	logic [31:0] header_word;
	logic [2:0]  word_number;
	logic        last_word;
	logic [31:0] next_hop;
	logic        via_router;

	// Shadow copy of the configuration registers, updated when a write is accepted.
	logic [31:0] own_q;
	logic [31:0] mask_q;
	logic [31:0] router_q;

	// Header words predicted for accepted requests, oldest first.
	hdr_word_t pending_words[$];

	int unsigned fail_count;
	int unsigned requests_sent;
	int unsigned words_checked;
	int unsigned routed_requests;
	int unsigned wrapped_requests;

	// Idling controls: the sender draws a wait per request and the receiver one per word when enabled.
	bit tx_idle_on;
	bit rx_idle_on;
	// A nonzero value makes the receiver hold word_ready low for a hold-off of that length.
	int unsigned rx_hold;

	ipv4_header_builder_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.dest_address (dest_address),
		.proto_number (proto_number),
		.payload_bytes(payload_bytes),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.header_word  (header_word),
		.word_number  (word_number),
		.last_word    (last_word),
		.next_hop     (next_hop),
		.via_router   (via_router)
	);

	always #5 clk = ~clk;

	// Builds the five header words for one request from the current configuration and
	// queues them. The total length wraps at 16 bits, and the checksum is the ones'
	// complement of the folded 16-bit sum over the header with the checksum field zero.
	function automatic void predict_header(input logic [31:0] dst, input logic [7:0] proto,
			input logic [15:0] pay);
		logic [15:0] total;
		logic [31:0] hdr [HdrWords];
		logic [31:0] sum;
		logic [31:0] hop;
		logic        via;
		hdr_word_t   item;
		total = pay + HdrBytes;
		hdr[0] = {VerIhlTos, total};
		hdr[1] = {IdentVal, FlagsFrag};
		hdr[2] = {TtlVal, proto, 16'h0000};
		hdr[3] = own_q;
		hdr[4] = dst;
		sum = 32'd0;
		for (int i = 0; i < HdrWords; i++) begin
			sum = sum + {16'h0000, hdr[i][31:16]} + {16'h0000, hdr[i][15:0]};
		end
		while (sum[31:16] != 16'h0000) begin
			sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
		end
		hdr[2][15:0] = ~sum[15:0];
		// A destination outside the own subnet goes to the gateway; a zero mask makes
		// every destination local.
		if ((dst & mask_q) != (own_q & mask_q)) begin
			hop = router_q;
			via = 1'b1;
			routed_requests++;
		end else begin
			hop = dst;
			via = 1'b0;
		end
		if ({1'b0, pay} + 17'd20 > 17'hFFFF) begin
			wrapped_requests++;
		end
		for (int i = 0; i < HdrWords; i++) begin
			item.header = hdr[i];
			item.number = 3'(i);
			item.last   = (i == HdrWords - 1);
			item.hop    = hop;
			item.via    = via;
			pending_words.push_back(item);
		end
	endfunction

	// Offers one request word and returns at the edge where it is accepted. The valid line
	// stays high on return so that a back-to-back request keeps it high without a dip.
	task automatic send_request(input logic [31:0] dst, input logic [7:0] proto,
			input logic [15:0] pay);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		dest_address  <= dst;
		proto_number  <= proto;
		payload_bytes <= pay;
		do @(posedge clk); while (!req_ready);
		predict_header(dst, proto, pay);
		requests_sent++;
	endtask

	// Drops the request valid and waits until every predicted word has been seen.
	task automatic wait_drain();
		req_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// Offers one register write and returns at the edge where it is accepted. The caller
	// lowers cfg_valid once its sequence of writes is done.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_OWN_ADDRESS: own_q = data;
			CFG_NET_MASK: mask_q = data;
			CFG_ROUTER_ADDRESS: router_q = data;
			default: ;
		endcase
	endtask

	// Rewrites all three registers; only called while the block is idle.
	task automatic set_config(input logic [31:0] own, input logic [31:0] mask,
			input logic [31:0] router);
		write_reg(CFG_OWN_ADDRESS, own);
		write_reg(CFG_NET_MASK, mask);
		write_reg(CFG_ROUTER_ADDRESS, router);
		cfg_valid <= 1'b0;
	endtask

	// Destinations lean toward the own subnet, with random and one-bit-off addresses mixed
	// in so that both next-hop choices come up under any nonzero mask.
	function automatic logic [31:0] pick_dest();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0, 1: pick_dest = (own_q & mask_q) | (r & ~mask_q);
			2: pick_dest = r;
			default: pick_dest = own_q ^ (32'h1 << $urandom_range(0, 31));
		endcase
	endfunction

	// Mostly legal payload lengths, sometimes one that makes the total length wrap.
	function automatic logic [15:0] pick_payload();
		if ($urandom_range(0, 9) == 0) begin
			pick_payload = 16'($urandom_range(65516, 65535));
		end else begin
			pick_payload = 16'($urandom_range(0, 65515));
		end
	endfunction

	// Mostly prefix masks of any length, sometimes an arbitrary bit pattern.
	function automatic logic [31:0] pick_mask();
		int unsigned len;
		len = $urandom_range(0, 32);
		if ($urandom_range(0, 4) == 0) begin
			pick_mask = $urandom;
		end else if (len == 0) begin
			pick_mask = 32'h0000_0000;
		end else begin
			pick_mask = 32'hFFFF_FFFF << (32 - len);
		end
	endfunction

	// Right after reset all registers are zero, so the mask is zero and every destination
	// is local, and the source address field is zero.
	task automatic test_reset_defaults();
		send_request(32'h0A00_0001, 8'd17, 16'd0);
		send_request(32'hFFFF_FFFF, 8'd6, 16'd1480);
		wait_drain();
	endtask

	// Field extremes, both next-hop outcomes and the wrapping total length.
	task automatic test_directed_fields();
		set_config(32'hC0A8_0164, 32'hFFFF_FF00, 32'hC0A8_0101);
		send_request(32'hC0A8_0107, 8'd6, 16'd100);
		send_request(32'h0808_0808, 8'd17, 16'd512);
		send_request(32'h0000_0000, 8'd0, 16'd0);
		send_request(32'hFFFF_FFFF, 8'd255, 16'd65515);
		send_request(32'hC0A8_01FF, 8'd1, 16'd65516);
		send_request(32'hC0A8_0000, 8'hAA, 16'd65535);
		send_request(32'h5555_5555, 8'h55, 16'h5555);
		send_request(32'hAAAA_AAAA, 8'hAA, 16'hAAAA);
		wait_drain();
	endtask

	// A write to the unused index must change nothing; the following headers still use
	// the old source, mask and gateway.
	task automatic test_unused_index();
		write_reg(CfgIdxUnused, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_request(32'hC0A8_0122, 8'd6, 16'd40);
		send_request(32'h0102_0304, 8'd17, 16'd8);
		wait_drain();
	endtask

	// Full mask: only the own address itself is local. Zero mask with nonzero registers:
	// every destination is local. All-ones source with a zero gateway.
	task automatic test_mask_extremes();
		set_config(32'h0A01_0203, 32'hFFFF_FFFF, 32'h0A01_0001);
		send_request(32'h0A01_0203, 8'd6, 16'd20);
		send_request(32'h0A01_0202, 8'd6, 16'd20);
		wait_drain();
		set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
		send_request(32'h0000_0000, 8'd132, 16'd1000);
		send_request(32'h8000_0001, 8'd47, 16'd65515);
		wait_drain();
		set_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		send_request(32'h7FFF_FFFF, 8'd89, 16'd7);
		send_request(32'h8000_0000, 8'd89, 16'd7);
		wait_drain();
	endtask

	// Several configurations, extremes among them, each followed by a stretch of random
	// requests. One phase runs without any idling on either side, two more without it on one side.
	task automatic test_random();
		logic [31:0] own;
		logic [31:0] mask;
		logic [31:0] router;
		for (int phase = 0; phase < 6; phase++) begin
			own    = $urandom;
			router = $urandom;
			case (phase)
				0: mask = 32'hFFFF_FF00;
				1: mask = 32'hFFFF_FFFF;
				2: mask = 32'h0000_0000;
				3: begin
					own    = 32'h0000_0000;
					router = 32'hFFFF_FFFF;
					mask   = pick_mask();
				end
				4: begin
					own    = 32'hFFFF_FFFF;
					router = 32'h0000_0000;
					mask   = pick_mask();
				end
				default: mask = pick_mask();
			endcase
			set_config(own, mask, router);
			tx_idle_on = (phase != 0) && (phase != 3);
			rx_idle_on = (phase != 0) && (phase != 4);
			for (int n = 0; n < 45; n++) begin
				send_request(pick_dest(), 8'($urandom), pick_payload());
			end
			// The sender pauses here until every predicted word has come back.
			wait_drain();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender offers requests back to
	// back, so the output stage and the request register fill and req_ready drops.
	task automatic test_backpressure();
		set_config($urandom, 32'hFFFF_0000, $urandom);
		tx_idle_on = 1'b0;
		rx_hold    = 200;
		for (int n = 0; n < 20; n++) begin
			send_request(pick_dest(), 8'($urandom), pick_payload());
		end
		wait_drain();
		tx_idle_on = 1'b1;
	endtask

	// Receiver: draws a stall before each word, or applies a requested long hold-off.
	initial begin
		int unsigned stall;
		word_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				word_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				stall = rx_idle_on ? $urandom_range(0, 11) : 0;
				if (stall > 0) begin
					word_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			word_ready <= 1'b1;
			do @(posedge clk); while (!word_valid);
		end
	end

	// Checker: every accepted header word is compared against the oldest prediction.
	always @(posedge clk) begin
		hdr_word_t exp_word;
		if (arst_n && word_valid && word_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected header word %h (number %0d)", header_word, word_number);
				fail_count++;
			end else begin
				exp_word = pending_words.pop_front();
				words_checked++;
				if (header_word !== exp_word.header) begin
					$error("header_word: expected %h, actual %h", exp_word.header, header_word);
					fail_count++;
				end
				if (word_number !== exp_word.number) begin
					$error("word_number: expected %0d, actual %0d", exp_word.number, word_number);
					fail_count++;
				end
				if (last_word !== exp_word.last) begin
					$error("last_word: expected %b, actual %b", exp_word.last, last_word);
					fail_count++;
				end
				if (next_hop !== exp_word.hop) begin
					$error("next_hop: expected %h, actual %h", exp_word.hop, next_hop);
					fail_count++;
				end
				if (via_router !== exp_word.via) begin
					$error("via_router: expected %b, actual %b", exp_word.via, via_router);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: the slowest correct run is far below this.
	initial begin
		#4ms;
		$display("timeout with %0d header words still expected", pending_words.size());
		$display("ipv4_header_builder_top: mismatch");
		$finish;
	end

	// Main sequence: reset once, then the tests in turn, then the final drain and verdict.
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 2'd0;
		cfg_data      = 32'd0;
		req_valid     = 1'b0;
		dest_address  = 32'd0;
		proto_number  = 8'd0;
		payload_bytes = 16'd0;
		own_q         = 32'd0;
		mask_q        = 32'd0;
		router_q      = 32'd0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		rx_hold       = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_fields();
		test_unused_index();
		test_mask_extremes();
		test_random();
		test_backpressure();

		// Once nothing is expected, wait on so that any stray word can still show.
		repeat (10) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d header words never arrived", pending_words.size());
			fail_count++;
		end
		$display("Sent %0d requests (%0d via the gateway, %0d with a wrapped length),",
			requests_sent, routed_requests, wrapped_requests);
		$display("checked %0d header words over several configurations, %0d failures.",
			words_checked, fail_count);
		if (fail_count == 0) begin
			$display("ipv4_header_builder_top: match");
		end else begin
			$display("ipv4_header_builder_top: mismatch");
		end
		$finish;
	end

endmodule
